// ===== hdl/gbtc_pkg.sv =====
`timescale 1ns / 1ps

package gbtc_pkg;

   localparam int CAPACITY = 256;
   localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CW       = (CNT_W > 9) ? CNT_W : 9;
   localparam int OUT_W    = 9;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_LEFT   = 3'd2,
      OP_RIGHT  = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } stat_type;

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic          rd_en;
      logic [AW-1:0] rd_addr;
      logic          wr_en;
      logic [AW-1:0] wr_addr;
      logic [7:0]    wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [7:0]       char_out;
      logic             char_valid;
      logic [OUT_W-1:0] text_length;
      logic [OUT_W-1:0] cursor;
      stat_type         status;
   } result_type;

endpackage

// ===== hdl/gbtc_store.sv =====
`timescale 1ns / 1ps

module gbtc_store (
   input  logic                 clock,
   input  gbtc_pkg::mem_req_type mem_req,
   output logic [7:0]           rd_data
);
   import gbtc_pkg::*;

   logic [7:0] mem [CAPACITY];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/gbtc_ctrl.sv =====
`timescale 1ns / 1ps

module gbtc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_opcode,
   input  logic [7:0]            req_char_in,
   input  logic [7:0]            req_position,
   input  logic                  out_free,
   output logic                  res_fire,
   output gbtc_pkg::result_type  res,
   output gbtc_pkg::mem_req_type mem_req,
   input  logic [7:0]            rd_data
);
   import gbtc_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] bc_ff, bc_in;
   logic [CNT_W-1:0] ac_ff, ac_in;
   logic             wr_en_ff, wr_en_in;
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;
   logic [7:0]       wr_data_ff;
   logic             wr_sel_ff, wr_sel_in;
   stat_type         status_ff, status_in;
   logic             char_valid_ff, char_valid_in;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             accept;
   logic [CW-1:0]    bc_w, ac_w, len_w, pos_w, cap_w, res_len_w;

   assign accept = req_valid && !req_stall;
   assign bc_w   = CW'(bc_ff);
   assign ac_w   = CW'(ac_ff);
   assign len_w  = bc_w + ac_w;
   assign pos_w  = CW'(req_position);
   assign cap_w  = CW'(CAPACITY);

   always_comb begin
      bc_in         = bc_ff;
      ac_in         = ac_ff;
      wr_en_in      = 1'b0;
      wr_addr_in    = AW'(bc_w);
      wr_sel_in     = 1'b0;
      status_in     = STAT_DONE;
      char_valid_in = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = AW'(pos_w);
      case (op_type'(req_opcode))
         OP_INSERT: begin
            if (len_w >= cap_w) begin
               status_in = STAT_FULL;
            end else begin
               wr_en_in = 1'b1;
               bc_in    = bc_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (bc_w == '0) begin
               status_in = STAT_EMPTY;
            end else begin
               bc_in = bc_ff - CNT_W'(1);
            end
         end
         OP_LEFT: begin
            if (bc_w == '0) begin
               status_in = STAT_EMPTY;
            end else begin
               rd_en      = 1'b1;
               rd_addr    = AW'(bc_w - CW'(1));
               wr_en_in   = 1'b1;
               wr_addr_in = AW'(cap_w - ac_w - CW'(1));
               wr_sel_in  = 1'b1;
               bc_in      = bc_ff - CNT_W'(1);
               ac_in      = ac_ff + CNT_W'(1);
            end
         end
         OP_RIGHT: begin
            if (ac_w == '0) begin
               status_in = STAT_EMPTY;
            end else begin
               rd_en      = 1'b1;
               rd_addr    = AW'(cap_w - ac_w);
               wr_en_in   = 1'b1;
               wr_sel_in  = 1'b1;
               bc_in      = bc_ff + CNT_W'(1);
               ac_in      = ac_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (pos_w >= len_w) begin
               status_in = STAT_RANGE;
            end else begin
               rd_en         = 1'b1;
               char_valid_in = 1'b1;
               if (pos_w < bc_w) begin
                  rd_addr = AW'(pos_w);
               end else begin
                  rd_addr = AW'(cap_w - ac_w + pos_w - bc_w);
               end
            end
         end
         default: begin
            status_in = STAT_DONE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      res_fire  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_FINISH: begin
            res_fire = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bc_ff    <= '0;
         ac_ff    <= '0;
         wr_en_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            bc_ff    <= bc_in;
            ac_ff    <= ac_in;
            wr_en_ff <= wr_en_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wr_addr_ff    <= wr_addr_in;
         wr_data_ff    <= req_char_in;
         wr_sel_ff     <= wr_sel_in;
         status_ff     <= status_in;
         char_valid_ff <= char_valid_in;
      end
   end

   assign mem_req.rd_en   = accept && rd_en;
   assign mem_req.rd_addr = rd_addr;
   assign mem_req.wr_en   = res_fire && wr_en_ff;
   assign mem_req.wr_addr = wr_addr_ff;
   assign mem_req.wr_data = wr_sel_ff ? rd_data : wr_data_ff;

   assign res_len_w       = CW'(bc_ff) + CW'(ac_ff);
   assign res.char_out    = char_valid_ff ? rd_data : 8'd0;
   assign res.char_valid  = char_valid_ff;
   assign res.text_length = res_len_w[OUT_W-1:0];
   assign res.cursor      = bc_w[OUT_W-1:0];
   assign res.status      = status_ff;

endmodule

// ===== hdl/gap_buffer_text_cursor.sv =====
`timescale 1ns / 1ps
// Gap buffer text store with an edit cursor, held in one synchronous memory.
// The request channel (req_valid, req_stall, req_opcode, req_char_in,
// req_position) carries one command per transfer: insert, delete before the
// cursor, cursor left, cursor right, or read the character at a position.
// Every command gives exactly one transfer on the response channel
// (rsp_valid, rsp_stall and the result fields), in command order.
// A command runs in two steps: in the first the memory read is issued and the
// counts are updated, in the second the read data returns, the write back is
// made and the result is loaded into the output register. A new command is not
// taken before the single read-modify-write pass is through, so req_stall is
// high in the cycle after each request transfer. The output register parts the
// two channels, so the next command is taken while a result waits; when that
// second result is ready and the first is still stalled, req_stall stays high
// until the first one is taken.
// Reset empties the text, puts the cursor at zero and drops rsp_valid; the
// memory contents are not cleared.

module gap_buffer_text_cursor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_char_in,
   input  logic [7:0] req_position,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_char_valid,
   output logic [8:0] rsp_text_length,
   output logic [8:0] rsp_cursor,
   output logic [1:0] rsp_status
);
   import gbtc_pkg::*;

   mem_req_type mem_req;
   result_type  res;
   result_type  res_ff;
   logic        rsp_valid_ff;
   logic        out_free;
   logic        res_fire;
   logic [7:0]  rd_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   gbtc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_char_in  (req_char_in),
      .req_position (req_position),
      .out_free     (out_free),
      .res_fire     (res_fire),
      .res          (res),
      .mem_req      (mem_req),
      .rd_data      (rd_data)
   );

   gbtc_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         res_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = res_ff.char_out;
   assign rsp_char_valid  = res_ff.char_valid;
   assign rsp_text_length = res_ff.text_length;
   assign rsp_cursor      = res_ff.cursor;
   assign rsp_status      = res_ff.status;

endmodule

// ===== hdl/gbtc_checker.sv =====
`timescale 1ns / 1ps

module gbtc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_char_out,
   input logic       rsp_char_valid,
   input logic [8:0] rsp_text_length,
   input logic [8:0] rsp_cursor,
   input logic [1:0] rsp_status
);
   import gbtc_pkg::*;

   a_reset_idle : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor)
         && $stable(rsp_status) && $stable(rsp_char_out))
      else $error("stalled response changed");

   a_cursor_in_text : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && CAPACITY < 512 |-> rsp_cursor <= rsp_text_length)
      else $error("cursor beyond text length");

   a_char_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_char_out == 8'd0)
      else $error("character output without a read");

   a_read_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> rsp_status == STAT_DONE)
      else $error("read character with error status");

endmodule

bind gap_buffer_text_cursor gbtc_checker u_gbtc_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import gbtc_pkg::*;

   localparam logic [2:0] OP_RSVD5 = 3'd5;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;
   localparam int ITEM_TARGET = 1650;
   localparam int HOLD_CYCLES = 150;
   localparam int CYCLE_LIMIT = 200000;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} edit_mode_type;

   typedef struct {
      logic [7:0] ch;
      logic       vld;
      logic [8:0] len;
      logic [8:0] cur;
      stat_type   st;
   } edit_result_type;

   typedef struct {
      logic [2:0]      op;
      logic [7:0]      ch;
      logic [7:0]      pos;
      bit              known;
      edit_result_type want;
   } edit_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_opcode = '0;
   logic [7:0] req_char_in = '0;
   logic [7:0] req_position = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_char_valid;
   logic [8:0] rsp_text_length;
   logic [8:0] rsp_cursor;
   logic [1:0] rsp_status;

   logic [7:0]      text_mem [0:CAPACITY-1];
   int              before_len = 0;
   int              after_len = 0;
   edit_result_type pending_results [$];
   edit_row_type    directed_rows [$];
   edit_result_type no_result;
   edit_result_type got_res;

   int  fail_count = 0;
   int  issued_count = 0;
   int  checked_count = 0;
   int  full_count = 0;
   int  empty_count = 0;
   int  range_count = 0;
   int  read_count = 0;
   int  peak_len = 0;
   int  cycle_count = 0;
   int  rx_wait = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   bit  tx_idle = 1'b1;
   bit  rx_idle = 1'b1;

   gap_buffer_text_cursor uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_char_in    (req_char_in),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_char_out   (rsp_char_out),
      .rsp_char_valid (rsp_char_valid),
      .rsp_text_length(rsp_text_length),
      .rsp_cursor     (rsp_cursor),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles.", cycle_count);
      $display("== FAIL ==");
      $finish;
   end

   function automatic edit_result_type apply_edit(logic [2:0] op, logic [7:0] ch,
                                                  logic [7:0] pos);
      edit_result_type r;
      int slot;
      r.ch = '0;
      r.vld = 1'b0;
      r.st = STAT_DONE;
      case (op)
         OP_INSERT: begin
            if (before_len + after_len >= CAPACITY) begin
               r.st = STAT_FULL;
            end else begin
               text_mem[before_len] = ch;
               before_len++;
            end
         end
         OP_DELETE: begin
            if (before_len == 0) r.st = STAT_EMPTY;
            else before_len--;
         end
         OP_LEFT: begin
            if (before_len == 0) begin
               r.st = STAT_EMPTY;
            end else begin
               before_len--;
               after_len++;
               text_mem[CAPACITY - after_len] = text_mem[before_len];
            end
         end
         OP_RIGHT: begin
            if (after_len == 0) begin
               r.st = STAT_EMPTY;
            end else begin
               text_mem[before_len] = text_mem[CAPACITY - after_len];
               after_len--;
               before_len++;
            end
         end
         OP_READ: begin
            if (int'(pos) >= before_len + after_len) begin
               r.st = STAT_RANGE;
            end else begin
               if (int'(pos) < before_len) slot = int'(pos);
               else slot = CAPACITY - after_len + int'(pos) - before_len;
               r.ch = text_mem[slot];
               r.vld = 1'b1;
            end
         end
         default: ;
      endcase
      r.len = 9'(before_len + after_len);
      r.cur = 9'(before_len);
      return r;
   endfunction

   function automatic void add_step(logic [2:0] op, logic [7:0] ch, logic [7:0] pos);
      edit_row_type row;
      row.op = op;
      row.ch = ch;
      row.pos = pos;
      row.known = 1'b0;
      row.want = no_result;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_step_known(logic [2:0] op, logic [7:0] ch, logic [7:0] pos,
                                          logic [7:0] ch_o, logic vld, int len, int cur,
                                          stat_type st);
      edit_row_type row;
      row.op = op;
      row.ch = ch;
      row.pos = pos;
      row.known = 1'b1;
      row.want.ch = ch_o;
      row.want.vld = vld;
      row.want.len = 9'(len);
      row.want.cur = 9'(cur);
      row.want.st = st;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [7:0] pick_position();
      int len;
      len = before_len + after_len;
      if (len > 0 && $urandom_range(0, 3) != 0) return 8'($urandom_range(0, len - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [2:0] pick_opcode(edit_mode_type mode);
      int roll;
      int t_ins;
      int t_del;
      int t_left;
      int t_right;
      int t_read;
      int spare;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_GROW: begin
            t_ins = 55; t_del = 62; t_left = 72; t_right = 82; t_read = 97;
         end
         MODE_SHRINK: begin
            t_ins = 10; t_del = 45; t_left = 60; t_right = 70; t_read = 95;
         end
         default: begin
            t_ins = 30; t_del = 45; t_left = 60; t_right = 75; t_read = 96;
         end
      endcase
      if (roll < t_ins) return OP_INSERT;
      if (roll < t_del) return OP_DELETE;
      if (roll < t_left) return OP_LEFT;
      if (roll < t_right) return OP_RIGHT;
      if (roll < t_read) return OP_READ;
      spare = $urandom_range(0, 2);
      if (spare == 0) return OP_RSVD5;
      if (spare == 1) return OP_RSVD6;
      return OP_RSVD7;
   endfunction

   // Entered at a falling edge; returns at the falling edge after the transfer.
   task automatic issue_cmd(input logic [2:0] op, input logic [7:0] ch,
                            input logic [7:0] pos, input bit known,
                            input edit_result_type want);
      int gap;
      edit_result_type pred;
      gap = tx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_char_in <= ch;
      req_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = apply_edit(op, ch, pos);
      pending_results.push_back(known ? want : pred);
      issued_count++;
      case (pred.st)
         STAT_FULL:  full_count++;
         STAT_EMPTY: empty_count++;
         STAT_RANGE: range_count++;
         default: ;
      endcase
      if (pred.vld) read_count++;
      if (int'(pred.len) > peak_len) peak_len = int'(pred.len);
      if (issued_count == 500 || issued_count == 1100) hold_request = 1'b1;
      if (issued_count % 100 == 0) tx_idle = 1'($urandom_range(0, 1));
      @(negedge clock);
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (rx_wait > 0) begin
            rsp_stall <= 1'b1;
            rx_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("Result transfer with no command outstanding.");
            fail_count++;
         end else begin
            got_res = pending_results.pop_front();
            if (rsp_char_out !== got_res.ch) begin
               $error("char_out: expected %0h, got %0h", got_res.ch, rsp_char_out);
               fail_count++;
            end
            if (rsp_char_valid !== got_res.vld) begin
               $error("char_valid: expected %0d, got %0d", got_res.vld, rsp_char_valid);
               fail_count++;
            end
            if (rsp_text_length !== got_res.len) begin
               $error("text_length: expected %0d, got %0d", got_res.len, rsp_text_length);
               fail_count++;
            end
            if (rsp_cursor !== got_res.cur) begin
               $error("cursor: expected %0d, got %0d", got_res.cur, rsp_cursor);
               fail_count++;
            end
            if (rsp_status !== got_res.st) begin
               $error("status: expected %0d, got %0d", got_res.st, rsp_status);
               fail_count++;
            end
         end
         checked_count++;
         if (checked_count % 100 == 0) rx_idle = 1'($urandom_range(0, 1));
         rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
      end
   end

   initial begin
      edit_row_type  row;
      edit_mode_type mode;
      logic [2:0]    op;

      no_result.ch = '0;
      no_result.vld = 1'b0;
      no_result.len = '0;
      no_result.cur = '0;
      no_result.st = STAT_DONE;
      mode = MODE_GROW;

      add_step_known(OP_READ,   8'h00, 8'h00, 8'h00, 1'b0, 0, 0, STAT_RANGE);
      add_step_known(OP_DELETE, 8'h11, 8'h22, 8'h00, 1'b0, 0, 0, STAT_EMPTY);
      add_step_known(OP_LEFT,   8'h00, 8'h00, 8'h00, 1'b0, 0, 0, STAT_EMPTY);
      add_step_known(OP_RIGHT,  8'h00, 8'h00, 8'h00, 1'b0, 0, 0, STAT_EMPTY);
      add_step_known(OP_RSVD7,  8'hFF, 8'hFF, 8'h00, 1'b0, 0, 0, STAT_DONE);
      add_step_known(OP_INSERT, 8'h00, 8'hFF, 8'h00, 1'b0, 1, 1, STAT_DONE);
      add_step_known(OP_INSERT, 8'hFF, 8'h00, 8'h00, 1'b0, 2, 2, STAT_DONE);
      add_step(OP_INSERT, 8'hA5, 8'h00);
      add_step(OP_LEFT,   8'h00, 8'h00);
      add_step(OP_LEFT,   8'h00, 8'h00);
      add_step_known(OP_READ,   8'h3C, 8'h00, 8'h00, 1'b1, 3, 1, STAT_DONE);
      add_step_known(OP_READ,   8'h00, 8'h01, 8'hFF, 1'b1, 3, 1, STAT_DONE);
      add_step(OP_READ,   8'h00, 8'h02);
      add_step_known(OP_READ,   8'h00, 8'h03, 8'h00, 1'b0, 3, 1, STAT_RANGE);
      add_step_known(OP_READ,   8'h00, 8'hFF, 8'h00, 1'b0, 3, 1, STAT_RANGE);
      add_step_known(OP_RSVD5,  8'h00, 8'h00, 8'h00, 1'b0, 3, 1, STAT_DONE);
      add_step_known(OP_RSVD6,  8'h00, 8'h00, 8'h00, 1'b0, 3, 1, STAT_DONE);
      add_step(OP_RIGHT,  8'h00, 8'h00);
      add_step(OP_DELETE, 8'h00, 8'h00);
      add_step(OP_READ,   8'h00, 8'h01);
      add_step(OP_INSERT, 8'h5A, 8'h00);
      add_step(OP_LEFT,   8'h00, 8'h00);
      add_step(OP_DELETE, 8'h00, 8'h00);
      add_step_known(OP_DELETE, 8'h00, 8'h00, 8'h00, 1'b0, 2, 0, STAT_EMPTY);
      add_step_known(OP_LEFT,   8'h00, 8'h00, 8'h00, 1'b0, 2, 0, STAT_EMPTY);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         issue_cmd(row.op, row.ch, row.pos, row.known, row.want);
      end

      // Fill the buffer to capacity with text on both sides of the cursor.
      while (before_len + after_len < CAPACITY) begin
         if (before_len > 0 && $urandom_range(0, 3) == 0) begin
            issue_cmd(OP_LEFT, 8'($urandom), 8'($urandom), 1'b0, no_result);
         end else begin
            issue_cmd(OP_INSERT, 8'($urandom), 8'($urandom), 1'b0, no_result);
         end
      end
      repeat (3) issue_cmd(OP_INSERT, 8'($urandom), 8'($urandom), 1'b0, no_result);
      issue_cmd(OP_READ, 8'($urandom), 8'hFF, 1'b0, no_result);
      repeat (20) issue_cmd(OP_READ, 8'($urandom), pick_position(), 1'b0, no_result);

      while (issued_count < ITEM_TARGET) begin
         if (issued_count % 150 == 0) begin
            case ($urandom_range(0, 2))
               0: mode = MODE_GROW;
               1: mode = MODE_SHRINK;
               default: mode = MODE_MIXED;
            endcase
         end
         op = pick_opcode(mode);
         issue_cmd(op, 8'($urandom), (op == OP_READ) ? pick_position() : 8'($urandom),
                   1'b0, no_result);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived.", pending_results.size());
         fail_count++;
      end

      $display("Run covered %0d edit commands and %0d result transfers, peak length %0d.",
               issued_count, checked_count, peak_len);
      $display("Seen: %0d refused inserts, %0d empty-side no-ops, %0d reads past end, %0d reads.",
               full_count, empty_count, range_count, read_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
